// ===== rtl/core/jrpe_pkg.sv =====
// Shared types, constants and codes of the joint recurrence pair engine.
`default_nettype none
package jrpe_pkg;

  localparam int MAX_SAMPLES_DEF   = 256;
  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int MAX_DIMENSION_DEF = 16;

  localparam int DIST_WIDTH = 20;
  localparam int DIM_WIDTH  = 5;
  localparam int DLY_WIDTH  = 8;
  localparam int IDX_WIDTH  = 8;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = 20;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] NORM_MANHATTAN = 2'd0;
  localparam logic [1:0] NORM_EUCLIDEAN = 2'd1;
  localparam logic [1:0] NORM_SUPREMUM  = 2'd2;
  localparam logic [1:0] NORM_NONE      = 2'd3;

  localparam logic [1:0] REG_DIMENSION = 2'd0;
  localparam logic [1:0] REG_DELAY     = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_NORM      = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic write_sample;
    logic clear_count;
    logic start_query;
    logic tap_read;
    logic tap_accum;
    logic sqrt_start;
    logic sqrt_step;
    logic finish;
  } jrpe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_full;
    logic in_range;
    logic last_tap;
    logic sqrt_done;
    logic euclid;
  } jrpe_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/jrpe_datapath.sv =====
// Datapath: sample stores, tap addressing, accumulators, square root and result word.
`default_nettype none
module jrpe_datapath
  import jrpe_pkg::*;
#(
  parameter int MAX_SAMPLES   = MAX_SAMPLES_DEF,
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  jrpe_cmd_t                        cmd,
  output jrpe_stat_t                       stat,
  input  wire  [1:0]                       op_in,
  input  wire signed [SAMPLE_WIDTH-1:0]    sample_first_in,
  input  wire signed [SAMPLE_WIDTH-1:0]    sample_second_in,
  input  wire  [IDX_WIDTH-1:0]             row_in,
  input  wire  [IDX_WIDTH-1:0]             col_in,
  input  wire                              cfg_we,
  input  wire  [CFG_IDX_WIDTH-1:0]         cfg_idx,
  input  wire  [CFG_DATA_WIDTH-1:0]        cfg_data,
  output logic [1:0]                       res_status,
  output logic [DIST_WIDTH-1:0]            res_dist_first,
  output logic [DIST_WIDTH-1:0]            res_dist_second,
  output logic                             res_recur_first,
  output logic                             res_recur_second
);

  localparam int AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int KW  = $clog2(MAX_DIMENSION + 1);
  localparam int DW  = SAMPLE_WIDTH + 1;
  localparam int SQW = 2 * DW;
  localparam int ACCW = SQW + KW;
  localparam int SPW = KW + DLY_WIDTH;
  localparam int RW  = (ACCW + 1) / 2 + 1;
  localparam int SQRT_STEPS = (ACCW + 1) / 2;
  localparam int THW = 2 * DIST_WIDTH;

  logic [DIM_WIDTH-1:0]  embed_dimension;
  logic [DLY_WIDTH-1:0]  embed_delay;
  logic [DIST_WIDTH-1:0] distance_threshold;
  logic [1:0]            norm_select;

  always_ff @(posedge clk) begin
    if (rst) begin
      embed_dimension    <= DIM_WIDTH'(1);
      embed_delay        <= DLY_WIDTH'(1);
      distance_threshold <= DIST_WIDTH'(256);
      norm_select        <= NORM_MANHATTAN;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DIMENSION: embed_dimension    <= cfg_data[DIM_WIDTH-1:0];
        REG_DELAY:     embed_delay        <= cfg_data[DLY_WIDTH-1:0];
        REG_THRESHOLD: distance_threshold <= cfg_data;
        REG_NORM:      norm_select        <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Effective dimension, delay and norm
  logic [KW-1:0]        dim_eff;
  logic [DLY_WIDTH-1:0] dly_eff;
  logic [1:0]           nrm_eff;
  always_comb begin
    if (embed_dimension == '0)
      dim_eff = KW'(1);
    else if (32'(embed_dimension) > MAX_DIMENSION)
      dim_eff = KW'(MAX_DIMENSION);
    else
      dim_eff = KW'(embed_dimension);
    dly_eff = (embed_delay == '0) ? DLY_WIDTH'(1) : embed_delay;
    nrm_eff = (norm_select == NORM_NONE) ? NORM_MANHATTAN : norm_select;
  end

  logic [CW-1:0] sample_count;
  logic signed [SAMPLE_WIDTH-1:0] store_first  [MAX_SAMPLES];
  logic signed [SAMPLE_WIDTH-1:0] store_second [MAX_SAMPLES];

  always_ff @(posedge clk) begin
    if (rst)
      sample_count <= '0;
    else if (cmd.clear_count)
      sample_count <= '0;
    else if (cmd.write_sample)
      sample_count <= sample_count + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.write_sample) begin
      store_first[sample_count[AW-1:0]]  <= sample_first_in;
      store_second[sample_count[AW-1:0]] <= sample_second_in;
    end
  end

  // Span and vector count
  logic [SPW-1:0] span;
  logic [SPW:0]   nv;
  always_comb begin
    span = SPW'(dim_eff - KW'(1)) * SPW'(dly_eff);
    nv = ((SPW+1)'(sample_count) > (SPW+1)'(span)) ?
         (SPW+1)'(sample_count) - (SPW+1)'(span) : '0;
  end

  assign stat.is_full  = (32'(sample_count) >= MAX_SAMPLES);
  assign stat.in_range = ((SPW+1)'(row_in) < nv) && ((SPW+1)'(col_in) < nv);
  assign stat.euclid   = (nrm_eff == NORM_EUCLIDEAN);

  // Tap walk: addresses advance by delay, wrapping modulo the store depth
  logic [KW-1:0] tap;
  logic [AW-1:0] addr_a, addr_b;
  logic [AW-1:0] dly_mod;
  assign dly_mod = AW'(32'(dly_eff) % MAX_SAMPLES);
  // tap has already advanced past the word being accumulated
  assign stat.last_tap = (tap == dim_eff);

  logic [AW-1:0] wrap_a, wrap_b;
  always_comb begin
    wrap_a = AW'((32'(addr_a) + 32'(dly_mod)) % MAX_SAMPLES);
    wrap_b = AW'((32'(addr_b) + 32'(dly_mod)) % MAX_SAMPLES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
    end else if (cmd.start_query) begin
      tap <= '0;
    end else if (cmd.tap_read) begin
      tap <= tap + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      addr_a <= AW'(32'(row_in) % MAX_SAMPLES);
      addr_b <= AW'(32'(col_in) % MAX_SAMPLES);
    end else if (cmd.tap_read) begin
      addr_a <= wrap_a;
      addr_b <= wrap_b;
    end
  end

  // Registered store reads
  logic signed [SAMPLE_WIDTH-1:0] f_a, f_b, s_a, s_b;
  always_ff @(posedge clk) begin
    if (cmd.tap_read) begin
      f_a <= store_first[addr_a];
      f_b <= store_first[addr_b];
      s_a <= store_second[addr_a];
      s_b <= store_second[addr_b];
    end
  end

  logic [DW-1:0] d_f, d_s;
  always_comb begin
    d_f = (f_a >= f_b) ? DW'(DW'(f_a) - DW'(f_b)) : DW'(DW'(f_b) - DW'(f_a));
    d_s = (s_a >= s_b) ? DW'(DW'(s_a) - DW'(s_b)) : DW'(DW'(s_b) - DW'(s_a));
  end

  logic [ACCW-1:0] acc_f, acc_s;
  logic [ACCW-1:0] term_f, term_s;
  always_comb begin
    if (nrm_eff == NORM_EUCLIDEAN) begin
      term_f = ACCW'(d_f * d_f);
      term_s = ACCW'(d_s * d_s);
    end else begin
      term_f = ACCW'(d_f);
      term_s = ACCW'(d_s);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      acc_f <= '0;
      acc_s <= '0;
    end else if (cmd.tap_accum) begin
      if (nrm_eff == NORM_SUPREMUM) begin
        if (term_f > acc_f) acc_f <= term_f;
        if (term_s > acc_s) acc_s <= term_s;
      end else begin
        acc_f <= acc_f + term_f;
        acc_s <= acc_s + term_s;
      end
    end
  end

  // Bit-pair restoring square root, both series side by side
  logic [ACCW-1:0] rem_f, rem_s;
  logic [RW-1:0]   root_f, root_s;
  logic [$clog2(SQRT_STEPS+1)-1:0] sq_cnt;
  logic [RW+1:0] trial_f, trial_s;
  logic [RW+1:0] win_f, win_s;
  logic [ACCW-1:0] rem_f_next, rem_s_next;

  logic [ACCW+1:0] accp_f, accp_s;
  assign accp_f = (ACCW+2)'(rem_f);
  assign accp_s = (ACCW+2)'(rem_s);

  always_comb begin
    win_f = (RW+2)'(accp_f >> (2 * (SQRT_STEPS - 1 - 32'(sq_cnt))));
    win_s = (RW+2)'(accp_s >> (2 * (SQRT_STEPS - 1 - 32'(sq_cnt))));
    trial_f = {root_f, 2'b01};
    trial_s = {root_s, 2'b01};
    rem_f_next = rem_f;
    rem_s_next = rem_s;
    if (win_f >= trial_f)
      rem_f_next = rem_f - (ACCW'(trial_f) << (2 * (SQRT_STEPS - 1 - 32'(sq_cnt))));
    if (win_s >= trial_s)
      rem_s_next = rem_s - (ACCW'(trial_s) << (2 * (SQRT_STEPS - 1 - 32'(sq_cnt))));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_cnt <= '0;
    end else if (cmd.sqrt_start) begin
      sq_cnt <= '0;
    end else if (cmd.sqrt_step) begin
      sq_cnt <= sq_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      // Fold in the last tap, which accumulates on this same edge
      rem_f  <= acc_f + term_f;
      rem_s  <= acc_s + term_s;
      root_f <= '0;
      root_s <= '0;
    end else if (cmd.sqrt_step) begin
      rem_f  <= rem_f_next;
      rem_s  <= rem_s_next;
      root_f <= {root_f[RW-2:0], (win_f >= trial_f)};
      root_s <= {root_s[RW-2:0], (win_s >= trial_s)};
    end
  end

  assign stat.sqrt_done = (32'(sq_cnt) == SQRT_STEPS - 1);

  // Recurrence test and saturation
  logic [THW-1:0] thr_sq;
  assign thr_sq = THW'(distance_threshold) * THW'(distance_threshold);
  localparam int XW = (ACCW > THW) ? ACCW : THW;
  logic rec_f, rec_s;
  logic [ACCW-1:0] full_f, full_s;
  always_comb begin
    if (nrm_eff == NORM_EUCLIDEAN) begin
      rec_f = XW'(acc_f) <= XW'(thr_sq);
      rec_s = XW'(acc_s) <= XW'(thr_sq);
      full_f = ACCW'(root_f);
      full_s = ACCW'(root_s);
    end else begin
      rec_f = XW'(acc_f) <= XW'(distance_threshold);
      rec_s = XW'(acc_s) <= XW'(distance_threshold);
      full_f = acc_f;
      full_s = acc_s;
    end
  end

  localparam int SW = (ACCW > DIST_WIDTH) ? ACCW : DIST_WIDTH;
  logic [DIST_WIDTH-1:0] sat_f, sat_s;
  assign sat_f = (SW'(full_f) > SW'({DIST_WIDTH{1'b1}})) ? '1 : full_f[DIST_WIDTH-1:0];
  assign sat_s = (SW'(full_s) > SW'({DIST_WIDTH{1'b1}})) ? '1 : full_s[DIST_WIDTH-1:0];

  // Result word
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status       <= ST_OK;
      res_dist_first   <= '0;
      res_dist_second  <= '0;
      res_recur_first  <= 1'b0;
      res_recur_second <= 1'b0;
      if (op_in == OP_LOAD && stat.is_full) begin
        res_status <= ST_FULL;
      end else if (op_in == OP_QUERY) begin
        if (!stat.in_range) begin
          res_status <= ST_RANGE;
        end else begin
          res_dist_first   <= sat_f;
          res_dist_second  <= sat_s;
          res_recur_first  <= rec_f;
          res_recur_second <= rec_s;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/jrpe_control.sv =====
// Controller: sequences loads, clears and the tap walk and square root of a query.
`default_nettype none
module jrpe_control
  import jrpe_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [1:0] op_in,
  output logic       out_valid,
  input  wire        out_stall,
  output jrpe_cmd_t  cmd,
  input  jrpe_stat_t stat
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_ACCUM = 6'b000100,
    S_SQRT  = 6'b001000,
    S_DONE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_full;

  // Item is held at the input until its result is formed
  logic take;
  assign take = (state == S_DONE);
  assign in_stall = !take;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && !out_full) begin
          if (op_in == OP_QUERY && stat.in_range) begin
            cmd.start_query = 1'b1;
            state_next = S_READ;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_READ: begin
        cmd.tap_read = 1'b1;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.tap_accum = 1'b1;
        if (stat.last_tap) begin
          if (stat.euclid) begin
            cmd.sqrt_start = 1'b1;
            state_next = S_SQRT;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          state_next = S_READ;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_done) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        cmd.write_sample = (op_in == OP_LOAD) && !stat.is_full;
        cmd.clear_count = (op_in == OP_CLEAR);
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (take)
        out_full <= 1'b1;
      else if (!out_stall)
        out_full <= 1'b0;
    end
  end

  assign out_valid = out_full;

endmodule
`default_nettype wire

// ===== rtl/core/joint_recurrence_pair_engine.sv =====
// Top level of the joint recurrence pair engine.
`default_nettype none
// Loads sample pairs into two stores and answers vector pair queries with the
// delay-embedded distance of each series, both recurrence bits and their AND.
// A load, clear or out-of-range query goes straight to its result; an in-range
// query walks the taps of the embedding, then runs the bit-pair square root under
// the euclidean norm. The rate is set by the single tap walk, which reads one tap
// pair from each store at a time, and the iterative root; a new word is not taken
// before the last one is through. The input word is held under stall until its result is registered.
module joint_recurrence_pair_engine
  import jrpe_pkg::*;
#(
  parameter int MAX_SAMPLES   = MAX_SAMPLES_DEF,
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [1:0]                     opcode,
  input  wire  signed [SAMPLE_WIDTH-1:0] sample_first,
  input  wire  signed [SAMPLE_WIDTH-1:0] sample_second,
  input  wire  [IDX_WIDTH-1:0]           row_index,
  input  wire  [IDX_WIDTH-1:0]           col_index,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [1:0]                     status,
  output logic [DIST_WIDTH-1:0]          distance_first,
  output logic [DIST_WIDTH-1:0]          distance_second,
  output logic                           recur_first,
  output logic                           recur_second,
  output logic                           joint_recur,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [CFG_IDX_WIDTH-1:0]       cfg_index,
  input  wire  [CFG_DATA_WIDTH-1:0]      cfg_data
);

  jrpe_cmd_t  cmd;
  jrpe_stat_t stat;

  assign cfg_ready = 1'b1;

  jrpe_control u_control (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op_in    (opcode),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  jrpe_datapath #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .op_in           (opcode),
    .sample_first_in (sample_first),
    .sample_second_in(sample_second),
    .row_in          (row_index),
    .col_in          (col_index),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_idx         (cfg_index),
    .cfg_data        (cfg_data),
    .res_status      (status),
    .res_dist_first  (distance_first),
    .res_dist_second (distance_second),
    .res_recur_first (recur_first),
    .res_recur_second(recur_second)
  );

  assign joint_recur = recur_first && recur_second;

`ifndef SYNTHESIS
  a_out_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("no result word after accepted item");
  a_joint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (joint_recur == (recur_first && recur_second)))
    else $error("joint bit mismatch");
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_RANGE) |-> (distance_first == '0 && !recur_first))
    else $error("range error carries data");
`endif

endmodule
`default_nettype wire

// ===== tb/joint_recurrence_pair_engine_checker.sv =====
// Predicts and checks every result word of the joint recurrence pair engine.
`timescale 1ns / 100ps
module joint_recurrence_pair_engine_checker
  import jrpe_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  wire                  in_stall,
  input  wire  [1:0]           opcode,
  input  wire  [15:0]          sample_first,
  input  wire  [15:0]          sample_second,
  input  wire  [7:0]           row_index,
  input  wire  [7:0]           col_index,
  input  wire                  out_valid,
  input  wire                  out_stall,
  input  wire  [1:0]           status,
  input  wire  [DIST_WIDTH-1:0] distance_first,
  input  wire  [DIST_WIDTH-1:0] distance_second,
  input  wire                  recur_first,
  input  wire                  recur_second,
  input  wire                  joint_recur,
  input  wire                  cfg_valid,
  input  wire                  cfg_ready,
  input  wire  [1:0]           cfg_index,
  input  wire  [19:0]          cfg_data,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [1:0]            status;
    logic [DIST_WIDTH-1:0] dist_a;
    logic [DIST_WIDTH-1:0] dist_b;
    logic                  rec_a;
    logic                  rec_b;
    logic                  joint;
  } pair_result_t;

  pair_result_t result_fifo[$];
  logic signed [15:0] series_a[256];
  logic signed [15:0] series_b[256];
  int unsigned fill;
  logic [4:0]  dim_reg;
  logic [7:0]  dly_reg;
  logic [19:0] thr_reg;
  logic [1:0]  norm_reg;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Distance of one series; rec gets the recurrence bit from the full value.
  function automatic logic [DIST_WIDTH-1:0] vector_distance(bit second, int i, int j,
      int dim, int dly, logic [1:0] nrm, output logic rec);
    longint unsigned acc, d, full;
    longint sa, sb;
    acc = 0;
    for (int k = 0; k < dim; k++) begin
      sa = second ? series_b[(i + k * dly) % 256] : series_a[(i + k * dly) % 256];
      sb = second ? series_b[(j + k * dly) % 256] : series_a[(j + k * dly) % 256];
      d = sa >= sb ? sa - sb : sb - sa;
      if (nrm == NORM_EUCLIDEAN) acc += d * d;
      else if (nrm == NORM_SUPREMUM) acc = d > acc ? d : acc;
      else acc += d;
    end
    if (nrm == NORM_EUCLIDEAN) begin
      rec = acc <= longint'(thr_reg) * longint'(thr_reg);
      full = int_sqrt(acc);
    end else begin
      rec = acc <= longint'(thr_reg);
      full = acc;
    end
    return full > 64'hFFFFF ? 20'hFFFFF : full[DIST_WIDTH-1:0];
  endfunction

  function automatic pair_result_t apply_word();
    pair_result_t r;
    int dim, dly, span, nv;
    logic [1:0] nrm;
    r = '0;
    if (opcode == OP_LOAD) begin
      if (fill >= 256) r.status = ST_FULL;
      else begin
        series_a[fill] = sample_first;
        series_b[fill] = sample_second;
        fill++;
      end
    end else if (opcode == OP_QUERY) begin
      dim = dim_reg == 0 ? 1 : (dim_reg > 16 ? 16 : dim_reg);
      dly = dly_reg == 0 ? 1 : dly_reg;
      nrm = norm_reg == NORM_NONE ? NORM_MANHATTAN : norm_reg;
      span = (dim - 1) * dly;
      nv = int'(fill) > span ? int'(fill) - span : 0;
      if (row_index >= nv || col_index >= nv) r.status = ST_RANGE;
      else begin
        r.dist_a = vector_distance(0, row_index, col_index, dim, dly, nrm, r.rec_a);
        r.dist_b = vector_distance(1, row_index, col_index, dim, dly, nrm, r.rec_b);
        r.joint = r.rec_a & r.rec_b;
      end
    end else if (opcode == OP_CLEAR) begin
      fill = 0;
    end
    return r;
  endfunction

  assign pending = result_fifo.size();

  always @(posedge clk) begin
    pair_result_t e;
    if (rst) begin
      fill = 0;
      dim_reg = 5'd1;
      dly_reg = 8'd1;
      thr_reg = 20'd256;
      norm_reg = NORM_MANHATTAN;
      result_fifo.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIMENSION: dim_reg = cfg_data[4:0];
          REG_DELAY:     dly_reg = cfg_data[7:0];
          REG_THRESHOLD: thr_reg = cfg_data;
          REG_NORM:      norm_reg = cfg_data[1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (result_fifo.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          e = result_fifo.pop_front();
          if (status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, status);
            fail_count++;
          end
          if (distance_first !== e.dist_a) begin
            $error("distance_first expected %0d actual %0d", e.dist_a, distance_first);
            fail_count++;
          end
          if (distance_second !== e.dist_b) begin
            $error("distance_second expected %0d actual %0d", e.dist_b, distance_second);
            fail_count++;
          end
          if (recur_first !== e.rec_a) begin
            $error("recur_first expected %0d actual %0d", e.rec_a, recur_first);
            fail_count++;
          end
          if (recur_second !== e.rec_b) begin
            $error("recur_second expected %0d actual %0d", e.rec_b, recur_second);
            fail_count++;
          end
          if (joint_recur !== e.joint) begin
            $error("joint_recur expected %0d actual %0d", e.joint, joint_recur);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) result_fifo.push_back(apply_word());
    end
  end

endmodule

// ===== tb/joint_recurrence_pair_engine_tb.sv =====
// Stimulus and verdict for the joint recurrence pair engine.
`timescale 1ns / 100ps
module joint_recurrence_pair_engine_tb
  import jrpe_pkg::*;
;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic [1:0] opcode = OP_LOAD;
  logic [15:0] sample_first = 0, sample_second = 0;
  logic [7:0] row_index = 0, col_index = 0;
  logic out_stall = 0;
  logic cfg_valid = 0;
  logic [1:0] cfg_index = REG_DIMENSION;
  logic [19:0] cfg_data = 0;
  wire in_stall, out_valid, cfg_ready;
  wire [1:0] status;
  wire [DIST_WIDTH-1:0] distance_first, distance_second;
  wire recur_first, recur_second, joint_recur;
  int fail_count, pending, idle_cycles;
  bit stim_done = 0;
  int fill_model;
  int sent_count = 0;

  always #5 clk = ~clk;

  joint_recurrence_pair_engine dut (.*);
  joint_recurrence_pair_engine_checker chk (.*);

  // Receiver side: random stall lengths per word.
  initial begin
    int w;
    @(posedge clk);
    while (1) begin
      w = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) w = 0;
      out_stall <= w != 0;
      repeat (w) @(posedge clk);
      out_stall <= 0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  // Watchdog on accepted traffic.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("joint_recurrence_pair_engine_tb: FAIL");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] op, int a, int b, int i, int j);
    int w;
    w = $urandom_range(0, 4);
    if (w != 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1;
    opcode <= op;
    sample_first <= a[15:0];
    sample_second <= b[15:0];
    row_index <= i[7:0];
    col_index <= j[7:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (op == OP_LOAD && fill_model < 256) fill_model++;
    if (op == OP_CLEAR) fill_model = 0;
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val[19:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic load_random(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0)
        send_word(OP_LOAD, $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF,
                  $urandom_range(0, 1) ? 16'h7FFF : 16'h8000, $urandom, $urandom);
      else
        send_word(OP_LOAD, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic query_random(int n, int reach);
    for (int k = 0; k < n; k++)
      send_word(OP_QUERY, $urandom, $urandom,
                $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, reach),
                $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, reach));
  endtask

  initial begin
    int reach;
    fill_model = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: empty query, extremes, unused opcode, clear, full store.
    send_word(OP_QUERY, 0, 0, 0, 0);
    send_word(OP_LOAD, 16'h8000, 16'h7FFF, 8'hFF, 8'hFF);
    send_word(OP_LOAD, 16'h7FFF, 16'h8000, 0, 0);
    send_word(OP_LOAD, 16'h0000, 16'hFFFF, 0, 0);
    send_word(OP_QUERY, 0, 0, 0, 1);
    send_word(OP_QUERY, 0, 0, 1, 2);
    send_word(OP_QUERY, 0, 0, 3, 0);
    send_word(OP_QUERY, 0, 0, 8'hFF, 8'hFF);
    send_word(OP_NONE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_word(OP_CLEAR, 0, 0, 0, 0);
    send_word(OP_QUERY, 0, 0, 0, 0);
    write_reg(REG_DIMENSION, 16);
    write_reg(REG_DELAY, 1);
    write_reg(REG_THRESHOLD, 20'hFFFFF);
    write_reg(REG_NORM, {18'd0, NORM_SUPREMUM});
    load_random(256);
    send_word(OP_LOAD, 16'h1234, 16'h4321, 0, 0);
    send_word(OP_QUERY, 0, 0, 0, 240);
    send_word(OP_QUERY, 0, 0, 241, 0);
    write_reg(REG_NORM, {18'd0, NORM_EUCLIDEAN});
    send_word(OP_QUERY, 0, 0, 0, 240);
    write_reg(REG_NORM, {18'd0, NORM_NONE});
    send_word(OP_QUERY, 0, 0, 7, 200);
    write_reg(REG_DIMENSION, 0);
    write_reg(REG_DELAY, 0);
    send_word(OP_QUERY, 0, 0, 255, 0);
    write_reg(REG_DIMENSION, 31);
    write_reg(REG_DELAY, 255);
    send_word(OP_QUERY, 0, 0, 0, 0);
    // Random phases: new settings, refill, then queries mostly in range.
    while (sent_count < 1000) begin
      write_reg(REG_DIMENSION, $urandom_range(0, 5) == 0 ? $urandom_range(0, 31)
                                                         : $urandom_range(1, 5));
      write_reg(REG_DELAY, $urandom_range(0, 5) == 0 ? $urandom_range(0, 255)
                                                     : $urandom_range(1, 8));
      write_reg(REG_THRESHOLD, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 70000));
      write_reg(REG_NORM, $urandom_range(0, 3));
      if ($urandom_range(0, 1))
        send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
      load_random($urandom_range(5, 60));
      reach = fill_model > 1 ? fill_model - 1 : 1;
      query_random(40, reach);
    end
    in_valid <= 0;
    stim_done = 1;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("joint_recurrence_pair_engine_tb: PASS");
    end else begin
      $display("joint_recurrence_pair_engine_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== joint_recurrence_pair_engine.f =====
rtl/core/jrpe_pkg.sv
rtl/core/jrpe_datapath.sv
rtl/core/jrpe_control.sv
rtl/core/joint_recurrence_pair_engine.sv
tb/joint_recurrence_pair_engine_checker.sv
tb/joint_recurrence_pair_engine_tb.sv
